// ===== rtl/core/lc3x_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3x_pkg
// shared types, constants and helpers for the lc-3 instruction executor
// ----------------------------------------------------------------------------
package lc3x_pkg;

    localparam int unsigned MemWordsDefault = 65536;

    localparam logic [15:0] StartAddrReset  = 16'h3000;
    localparam logic [15:0] StackBaseReset  = 16'h4000;
    localparam logic [15:0] StackLimitReset = 16'h3C00;
    localparam logic [15:0] StackTopReset   = 16'h3FFF;

    localparam logic [1:0] KindExec  = 2'd0;
    localparam logic [1:0] KindWrite = 2'd1;
    localparam logic [1:0] KindRead  = 2'd2;

    localparam logic [1:0] RegStartAddr  = 2'd0;
    localparam logic [1:0] RegStackBase  = 2'd1;
    localparam logic [1:0] RegStackLimit = 2'd2;
    localparam logic [1:0] RegStackTop   = 2'd3;

    localparam logic [3:0] OpBr   = 4'd0;
    localparam logic [3:0] OpAdd  = 4'd1;
    localparam logic [3:0] OpLd   = 4'd2;
    localparam logic [3:0] OpSt   = 4'd3;
    localparam logic [3:0] OpJsr  = 4'd4;
    localparam logic [3:0] OpAnd  = 4'd5;
    localparam logic [3:0] OpLdr  = 4'd6;
    localparam logic [3:0] OpStr  = 4'd7;
    localparam logic [3:0] OpRti  = 4'd8;
    localparam logic [3:0] OpNot  = 4'd9;
    localparam logic [3:0] OpLdi  = 4'd10;
    localparam logic [3:0] OpSti  = 4'd11;
    localparam logic [3:0] OpJmp  = 4'd12;
    localparam logic [3:0] OpStk  = 4'd13;
    localparam logic [3:0] OpLea  = 4'd14;
    localparam logic [3:0] OpTrap = 4'd15;

    localparam logic [7:0] TrapGetc = 8'h20;
    localparam logic [7:0] TrapOut  = 8'h21;
    localparam logic [7:0] TrapPuts = 8'h22;
    localparam logic [7:0] TrapHalt = 8'h25;

    localparam logic [1:0] StkNone = 2'd0;
    localparam logic [1:0] StkOk   = 2'd1;
    localparam logic [1:0] StkFail = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic [7:0]  key_char;
    } t_in_item;

    typedef struct packed {
        logic [15:0] program_counter;
        logic        halted;
        logic [7:0]  char_out;
        logic        char_valid;
        logic [15:0] read_word;
        logic [1:0]  stack_status;
    } t_out_item;

    // memory address source select
    typedef enum logic [2:0] {
        ASEL_PC   = 3'd0,
        ASEL_ITEM = 3'd1,
        ASEL_EA   = 3'd2,
        ASEL_DATA = 3'd3,
        ASEL_SP   = 3'd4,
        ASEL_SPM1 = 3'd5,
        ASEL_R0   = 3'd6
    } t_asel;

    // controller to datapath
    typedef struct packed {
        logic  load_item;
        logic  mem_rd;
        logic  mem_wr;
        t_asel asel;
        logic  load_ir;
        logic  execute;
        logic  finish;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       halted;
        logic [3:0] op;
        logic       trap_puts;
        logic       stk_ok;
        logic       stk_pop;
    } t_ctl_sts;

    function automatic logic [15:0] sext9(input logic [15:0] ir);
        sext9 = {{7{ir[8]}}, ir[8:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] ir);
        sext6 = {{10{ir[5]}}, ir[5:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] ir);
        sext11 = {{5{ir[10]}}, ir[10:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] ir);
        sext5 = {{11{ir[4]}}, ir[4:0]};
    endfunction

endpackage

// ===== rtl/core/lc3x_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc3x_ctrl
// sequencing state machine: fetch, memory phases and result strobe
// ----------------------------------------------------------------------------
module lc3x_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  lc3x_pkg::t_ctl_sts i_sts,
    output lc3x_pkg::t_ctl_cmd o_cmd
);
    import lc3x_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_FETCH  = 8'b00000010,
        S_DECODE = 8'b00000100,
        S_MEM1   = 8'b00001000,
        S_MEM1W  = 8'b00010000,
        S_MEM2   = 8'b00100000,
        S_EXEC   = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.asel = ASEL_PC;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_sts.kind == KindWrite) begin
                    o_cmd.asel = ASEL_ITEM;
                    o_cmd.mem_wr = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.kind == KindRead) begin
                    o_cmd.asel = ASEL_ITEM;
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_EXEC;
                end else if (i_sts.kind == KindExec && !i_sts.halted) begin
                    o_cmd.asel = ASEL_PC;
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_DECODE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DECODE: begin
                o_cmd.load_ir = 1'b1;
                n_state = S_MEM1;
            end
            S_MEM1: begin
                // first data access, if the instruction needs one
                case (i_sts.op)
                    OpLd, OpLdi, OpLdr: begin
                        o_cmd.asel = ASEL_EA;
                        o_cmd.mem_rd = 1'b1;
                        n_state = (i_sts.op == OpLdi) ? S_MEM1W : S_EXEC;
                    end
                    OpSti: begin
                        o_cmd.asel = ASEL_EA;
                        o_cmd.mem_rd = 1'b1;
                        n_state = S_MEM1W;
                    end
                    OpSt, OpStr: begin
                        o_cmd.asel = ASEL_EA;
                        o_cmd.mem_wr = 1'b1;
                        n_state = S_EXEC;
                    end
                    OpStk: begin
                        if (i_sts.stk_ok && !i_sts.stk_pop) begin
                            o_cmd.asel = ASEL_SPM1;
                            o_cmd.mem_wr = 1'b1;
                        end else if (i_sts.stk_ok) begin
                            o_cmd.asel = ASEL_SP;
                            o_cmd.mem_rd = 1'b1;
                        end
                        n_state = S_EXEC;
                    end
                    OpTrap: begin
                        if (i_sts.trap_puts) begin
                            o_cmd.asel = ASEL_R0;
                            o_cmd.mem_rd = 1'b1;
                        end
                        n_state = S_EXEC;
                    end
                    default: begin
                        n_state = S_EXEC;
                    end
                endcase
            end
            S_MEM1W: begin
                n_state = S_MEM2;
            end
            S_MEM2: begin
                o_cmd.asel = ASEL_DATA;
                if (i_sts.op == OpSti) begin
                    o_cmd.mem_wr = 1'b1;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = (i_sts.kind == KindExec);
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("done must return to idle");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |-> r_state == S_IDLE)
        else $error("item loaded while busy");
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mem_rd && o_cmd.mem_wr))
        else $error("memory read and write together");
`endif

endmodule

// ===== rtl/core/lc3x_dp.sv =====
// ----------------------------------------------------------------------------
// lc3x_dp
// datapath: memory, register file, pc, condition codes and config registers
// ----------------------------------------------------------------------------
module lc3x_dp #(
    parameter int unsigned MEM_WORDS = lc3x_pkg::MemWordsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lc3x_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic [15:0]         o_cfg_rdata,
    input  lc3x_pkg::t_ctl_cmd  i_cmd,
    output lc3x_pkg::t_ctl_sts  o_sts,
    output lc3x_pkg::t_out_item o_result,
    output logic                o_result_valid
);
    import lc3x_pkg::*;

    localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_rdata;
    logic        r_rd_ok;

    t_in_item    r_item;
    logic [15:0] r_ir;
    logic [15:0] r_gpr [8];
    logic [15:0] r_pc;
    logic [2:0]  r_cc;
    logic        r_halt;
    logic [15:0] r_start, r_base, r_limit, r_top;
    logic [15:0] r_data1;
    logic [7:0]  r_ch;
    logic        r_chv;
    logic [15:0] r_rw;
    logic [1:0]  r_ss;
    logic        r_out_v;

    logic [15:0] pc1, ea, maddr, mdata, wval, rdata, sr1v, sr2v, drv, opb;
    logic [15:0] exec_pc;
    logic [3:0]  op;
    logic [2:0]  dr;
    logic        stk_ok;

    assign op   = r_ir[15:12];
    assign dr   = r_ir[11:9];
    assign pc1  = r_pc + 16'd1;
    assign sr1v = r_gpr[r_ir[8:6]];
    assign sr2v = r_gpr[r_ir[2:0]];
    assign drv  = r_gpr[dr];
    assign opb  = r_ir[5] ? sext5(r_ir) : sr2v;
    assign rdata = r_rd_ok ? r_rdata : 16'd0;
    assign stk_ok = r_ir[5] ? !(r_gpr[6] > r_top) : !(r_gpr[6] < r_limit);

    always_comb begin
        if (op == OpLdr || op == OpStr) begin
            ea = sr1v + sext6(r_ir);
        end else begin
            ea = pc1 + sext9(r_ir);
        end
    end

    always_comb begin
        exec_pc = pc1;
        case (op)
            OpBr: begin
                if ((dr & r_cc) != 3'd0) exec_pc = ea;
            end
            OpJmp:   exec_pc = sr1v;
            OpJsr:   exec_pc = r_ir[11] ? (pc1 + sext11(r_ir)) : sr1v;
            default: exec_pc = pc1;
        endcase
    end

    always_comb begin
        maddr = r_pc;
        mdata = drv;
        case (i_cmd.asel)
            ASEL_PC:   maddr = r_pc;
            ASEL_ITEM: begin
                maddr = r_item.mem_address;
                mdata = r_item.mem_value;
            end
            ASEL_EA:   maddr = ea;
            ASEL_DATA: maddr = r_data1;
            ASEL_SP:   maddr = r_gpr[6];
            ASEL_SPM1: begin
                // r5 is set to one before the source register is read
                maddr = r_gpr[6] - 16'd1;
                mdata = (dr == 3'd5) ? 16'd1 : drv;
            end
            ASEL_R0:   maddr = r_gpr[0];
            default:   maddr = r_pc;
        endcase
    end

    // memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && (32'(maddr) < MEM_WORDS)) begin
            r_mem[maddr[AW-1:0]] <= mdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[maddr[AW-1:0]];
            r_rd_ok <= (32'(maddr) < MEM_WORDS);
        end
    end

    assign o_sts.kind      = r_item.opcode;
    assign o_sts.halted    = r_halt;
    assign o_sts.op        = op;
    assign o_sts.trap_puts = (r_ir[7:0] == TrapPuts);
    assign o_sts.stk_ok    = stk_ok;
    assign o_sts.stk_pop   = r_ir[5];

    always_comb begin
        wval = 16'd0;
        case (op)
            OpAdd:   wval = sr1v + opb;
            OpAnd:   wval = sr1v & opb;
            OpNot:   wval = ~sr1v;
            default: wval = rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.load_ir) begin
            r_ir <= rdata;
        end
        if (i_cmd.mem_rd) begin
            r_data1 <= r_data1;
        end
        if (!i_cmd.mem_rd && !i_cmd.load_ir) begin
            r_data1 <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= StartAddrReset;
            r_base  <= StackBaseReset;
            r_limit <= StackLimitReset;
            r_top   <= StackTopReset;
            r_pc    <= StartAddrReset;
            r_cc    <= 3'b010;
            r_halt  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_gpr[i] <= (i == 6) ? StackBaseReset : 16'd0;
            end
            r_ch    <= 8'd0;
            r_chv   <= 1'b0;
            r_rw    <= 16'd0;
            r_ss    <= StkNone;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= i_cmd.finish;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegStartAddr: begin
                        r_start <= i_cfg_data;
                        r_pc    <= i_cfg_data;
                    end
                    RegStackBase: begin
                        r_base   <= i_cfg_data;
                        r_gpr[6] <= i_cfg_data;
                    end
                    RegStackLimit: r_limit <= i_cfg_data;
                    RegStackTop:   r_top   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_item) begin
                r_ch  <= 8'd0;
                r_chv <= 1'b0;
                r_rw  <= 16'd0;
                r_ss  <= StkNone;
            end
            if (i_cmd.execute) begin
                r_pc <= exec_pc;
                unique case (op)
                    OpAdd, OpAnd, OpNot, OpLd, OpLdi, OpLdr: begin
                        r_gpr[dr] <= wval;
                        r_cc <= (wval == 16'd0) ? 3'b010 :
                                (wval[15] ? 3'b100 : 3'b001);
                    end
                    OpJsr: r_gpr[7] <= pc1;
                    OpLea: r_gpr[dr] <= ea;
                    OpStk: begin
                        if (!stk_ok) begin
                            r_gpr[5] <= 16'd0;
                            r_ss <= StkFail;
                        end else begin
                            r_ss <= StkOk;
                            if (r_ir[5]) begin
                                // popped value wins over r5 and r6 updates
                                if (dr != 3'd6) r_gpr[6] <= r_gpr[6] + 16'd1;
                                if (dr != 3'd5) r_gpr[5] <= 16'd1;
                                r_gpr[dr] <= rdata;
                            end else begin
                                r_gpr[5] <= 16'd1;
                                r_gpr[6] <= r_gpr[6] - 16'd1;
                            end
                        end
                    end
                    OpTrap: begin
                        case (r_ir[7:0])
                            TrapGetc: begin
                                r_gpr[7] <= pc1;
                                r_gpr[0] <= {8'd0, r_item.key_char};
                            end
                            TrapOut: begin
                                r_gpr[7] <= pc1;
                                r_ch  <= r_gpr[0][7:0];
                                r_chv <= 1'b1;
                            end
                            TrapPuts: begin
                                r_gpr[7] <= pc1;
                                r_gpr[0] <= r_gpr[0] + 16'd1;
                                r_ch  <= rdata[7:0];
                                r_chv <= 1'b1;
                            end
                            TrapHalt: begin
                                r_gpr[7] <= pc1;
                                r_halt <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end else if (i_cmd.finish && r_item.opcode == KindRead) begin
                r_rw <= r_data1;
            end
        end
    end

    always_comb begin
        o_cfg_rdata = r_start;
        case (i_cfg_idx)
            RegStartAddr:  o_cfg_rdata = r_start;
            RegStackBase:  o_cfg_rdata = r_base;
            RegStackLimit: o_cfg_rdata = r_limit;
            default:       o_cfg_rdata = r_top;
        endcase
    end

    assign o_result.program_counter = r_pc;
    assign o_result.halted          = r_halt;
    assign o_result.char_out        = r_ch;
    assign o_result.char_valid      = r_chv;
    assign o_result.read_word       = r_rw;
    assign o_result.stack_status    = r_ss;
    assign o_result_valid           = r_out_v;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");
    a_exec_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_item.opcode == KindExec |-> !r_halt)
        else $error("instruction executed while halted");
    a_chv_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_chv |-> r_ch == 8'd0)
        else $error("character without valid");
`endif

endmodule

// ===== rtl/core/lc3_instruction_executor_top.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_executor_top
// lc-3 core with word memory, apb configuration and start/busy command port
// ----------------------------------------------------------------------------
// states, start to strobe: writes, halted and unused items pass fetch, done;
// reads add exec; instructions add decode, mem1, exec; ldi/sti mem1w, mem2
// throughput: one transaction at a time; next start accepted with the strobe
// result strobe is one cycle wide; the receiver cannot stall
// reset: synchronous active low; registers, pc and flags take reset values,
// memory contents are undefined until written
module lc3_instruction_executor_top #(
    parameter int unsigned MEM_WORDS = lc3x_pkg::MemWordsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lc3x_pkg::t_in_item  i_item,
    output lc3x_pkg::t_out_item o_result,
    output logic                o_result_valid,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lc3x_pkg::*;

    t_ctl_cmd    cmd;
    t_ctl_sts    sts;
    logic [15:0] cfg_rdata;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0);
    assign prdata = {16'd0, cfg_rdata};

    lc3x_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lc3x_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (paddr[3:2]),
        .i_cfg_data     (pwdata[15:0]),
        .o_cfg_rdata    (cfg_rdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
